// ===== rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scan core.
`timescale 1ns / 1ps

package wbps_pkg;

   // Field and register widths fixed by the register map
   localparam int BYTE_BITS         = 8;
   localparam int FIELD_OFFSET_BITS = 32;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 64;
   localparam int WILD_BITS         = 16;
   localparam int LENGTH_BITS       = 5;
   localparam int REG_PATTERN_BYTES = 8;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WILDCARD     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH       = 2'd3;

   // Control for the window cells
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // One result word
   typedef struct packed {
      logic                         found;
      logic [FIELD_OFFSET_BITS-1:0] match_offset;
   } rsp_word_type;

endpackage

// ===== rtl/wbps_cell.sv =====
// One window cell: holds a byte, passes it on and checks it against its pattern byte.
`timescale 1ns / 1ps

module wbps_cell
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int CELL_INDEX        = 0,
   parameter int LEN_W             = 5
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  cell_ctrl_type                              ctrl,
   input  logic [BYTE_BITS-1:0]                       byte_in,
   input  logic [LEN_W-1:0]                           length,
   input  logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] pattern,
   input  logic [MAX_PATTERN_BYTES-1:0]               wild,
   output logic [BYTE_BITS-1:0]                       byte_out,
   output logic                                       hit
);

   localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [BYTE_BITS-1:0] held_ff;
   logic [BYTE_BITS-1:0] held_in;
   logic                 in_use;
   logic [LEN_W-1:0]     pat_pos;
   logic [IDX_W-1:0]     pat_idx;

   // Pattern byte that lines up with this cell for the current length
   assign in_use  = length > LEN_W'(CELL_INDEX);
   assign pat_pos = length - LEN_W'(1) - LEN_W'(CELL_INDEX);
   assign pat_idx = pat_pos[IDX_W-1:0];

   // Compare the byte that moves in on this step
   assign hit = !in_use || wild[pat_idx] || (byte_in == pattern[pat_idx]);

   // Advance or clear the stored byte
   always_comb begin
      held_in = held_ff;
      if (ctrl.clear) begin
         held_in = '0;
      end else if (ctrl.shift) begin
         held_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign byte_out = held_ff;

endmodule

// ===== rtl/wbps_out_buf.sv =====
// Two-word result buffer: output register plus skid register.
`timescale 1ns / 1ps

module wbps_out_buf
   import wbps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic         main_valid_ff;
   logic         main_valid_in;
   rsp_word_type main_word_ff;
   rsp_word_type main_word_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_word_type skid_word_ff;
   rsp_word_type skid_word_in;
   logic         pop;

   assign pop   = main_valid_ff && rsp_ready;
   assign space = !skid_valid_ff;

   // Refill from the skid first, otherwise take the new word
   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_word_in  = push_word;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_word_in  = push_word;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold words without reset
   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_word_ff;

endmodule

// ===== rtl/wildcard_byte_pattern_scan_core.sv =====
// Wildcard byte pattern scan: image bytes in, one found/offset word per image out.
// Input channel req_*: one image byte per word, req_last_byte marks the final byte.
// Output channel rsp_*: rsp_found and rsp_match_offset; at most one word per image,
// given on the first match or on the final byte when nothing matched.
// Configuration port csr_*: pattern bytes, wildcard mask and pattern length,
// written while no scan word is in flight.
// A byte is taken every cycle while req_ready is high; the comparison runs across
// a row of window cells, one per pattern byte, each comparing the byte moving into it
// with the pattern byte that lines up with it, so the whole window is checked in the
// accept cycle. The result word is registered in the output buffer before it shows
// on rsp_valid. A two-word output buffer lets the scan go on while a result waits;
// req_ready drops only when both words are held, and rises again the cycle after
// rsp_ready takes one.
// After a match, bytes up to the final byte are taken and dropped.
// Reset clears the window, byte count and buffer, sets pattern length to one and
// the pattern and mask to zero. State also clears after every final byte.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_core
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [BYTE_BITS-1:0]         req_data_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [FIELD_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_write_data
);

   localparam int LEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int EXT_BITS = (OFFSET_BITS > FIELD_OFFSET_BITS) ? OFFSET_BITS
                                                               : FIELD_OFFSET_BITS + 1;

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [WILD_BITS-1:0]     wild_mask_ff;
   logic [LENGTH_BITS-1:0]   pattern_length_ff;

   // Scan state
   logic [OFFSET_BITS-1:0]   bytes_seen_ff;
   logic [OFFSET_BITS-1:0]   bytes_seen_in;
   logic                     scan_done_ff;
   logic                     scan_done_in;

   logic                                        accept;
   logic                                        step;
   logic [6:0]                                  len_ext;
   logic [LEN_W-1:0]                            used_len;
   logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] pattern;
   logic [MAX_PATTERN_BYTES-1:0]                wild;
   logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] window;
   logic [MAX_PATTERN_BYTES-1:0]                hits;
   cell_ctrl_type                               cell_ctrl;
   logic                                        saturated;
   logic [OFFSET_BITS-1:0]                      seen_next;
   logic                                        match;
   logic [OFFSET_BITS-1:0]                      offset_raw;
   logic [EXT_BITS-1:0]                         offset_ext;
   logic                                        push;
   rsp_word_type                                push_word;
   rsp_word_type                                rsp_word;
   logic                                        space;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wild_mask_ff      <= '0;
         pattern_length_ff <= LENGTH_BITS'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_WILDCARD:     wild_mask_ff      <= csr_write_data[WILD_BITS-1:0];
            CSR_LENGTH:       pattern_length_ff <= csr_write_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp length into one to the window depth
   assign len_ext = 7'(pattern_length_ff);
   always_comb begin
      if (len_ext == 7'd0) begin
         used_len = LEN_W'(1);
      end else if (len_ext > 7'(MAX_PATTERN_BYTES)) begin
         used_len = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         used_len = LEN_W'(len_ext);
      end
   end

   // Lay the pattern out per byte; bytes beyond the registers are zero, never wild
   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_pat
      if (k < REG_PATTERN_BYTES) begin : g_low
         assign pattern[k] = pattern_low_ff[BYTE_BITS*k +: BYTE_BITS];
         assign wild[k]    = wild_mask_ff[k];
      end else if (k < 2 * REG_PATTERN_BYTES) begin : g_high
         assign pattern[k] = pattern_high_ff[BYTE_BITS*(k-REG_PATTERN_BYTES) +: BYTE_BITS];
         assign wild[k]    = wild_mask_ff[k];
      end else begin : g_none
         assign pattern[k] = '0;
         assign wild[k]    = 1'b0;
      end
   end

   assign accept = req_valid && req_ready;
   assign step   = accept && !scan_done_ff;

   assign cell_ctrl.shift = step;
   assign cell_ctrl.clear = accept && req_last_byte;

   // Row of window cells, newest byte in cell zero
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [BYTE_BITS-1:0] cell_in;
      if (i == 0) begin : g_head
         assign cell_in = req_data_byte;
      end else begin : g_link
         assign cell_in = window[i-1];
      end
      wbps_cell #(
         .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
         .CELL_INDEX        (i),
         .LEN_W             (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .byte_in  (cell_in),
         .length   (used_len),
         .pattern  (pattern),
         .wild     (wild),
         .byte_out (window[i]),
         .hit      (hits[i])
      );
   end

   // Count bytes, saturating
   assign saturated = &bytes_seen_ff;
   assign seen_next = saturated ? bytes_seen_ff : bytes_seen_ff + OFFSET_BITS'(1);
   assign match     = (&hits) && (seen_next >= OFFSET_BITS'(used_len));

   // Start offset, clipped to the field
   assign offset_raw = saturated ? {OFFSET_BITS{1'b1}} : seen_next - OFFSET_BITS'(used_len);
   assign offset_ext = EXT_BITS'(offset_raw);

   always_comb begin
      push_word.found        = match;
      push_word.match_offset = '0;
      if (match) begin
         if (offset_ext > EXT_BITS'({FIELD_OFFSET_BITS{1'b1}})) begin
            push_word.match_offset = '1;
         end else begin
            push_word.match_offset = offset_ext[FIELD_OFFSET_BITS-1:0];
         end
      end
   end

   assign push = step && (match || req_last_byte);

   // Advance scan state; drop it after the final byte
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      scan_done_in  = scan_done_ff;
      if (step) begin
         bytes_seen_in = seen_next;
         if (match) begin
            scan_done_in = 1'b1;
         end
      end
      if (accept && req_last_byte) begin
         bytes_seen_in = '0;
         scan_done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         scan_done_ff  <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         scan_done_ff  <= scan_done_in;
      end
   end

   wbps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign req_ready        = space;
   assign rsp_found        = rsp_word.found;
   assign rsp_match_offset = rsp_word.match_offset;

endmodule

// ===== rtl/wbps_checker.sv =====
// Port-level checks for the scan core, bound to the top level.
`timescale 1ns / 1ps

module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_match_offset
);

   // No result word straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
                                  && $stable(rsp_match_offset))
      else $error("stalled result word changed");

   // A miss carries offset zero
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0)
      else $error("miss word with nonzero offset");

   // Input back-pressure only follows a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("input stalled without a waiting result word");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (.*);

// ===== tb/wildcard_byte_pattern_scan_core_tb.sv =====
// Self-checking testbench for the wildcard byte pattern scan core.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_core_tb
   import wbps_pkg::*;
();

   localparam int PATTERN_SLOTS     = 16;
   localparam int LONG_STALL_CYCLES = 80;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int PHASE_COUNT       = 13;
   localparam int PHASE_BYTES       = 125;
   localparam int REPORT_LIMIT      = 10;
   localparam int SETTLE_CYCLES     = 4;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
   } image_word_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [BYTE_BITS-1:0]         req_data_byte  = '0;
   logic                         req_last_byte  = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic                         rsp_found;
   logic [FIELD_OFFSET_BITS-1:0] rsp_match_offset;
   logic                         csr_write_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index      = '0;
   logic [CSR_DATA_BITS-1:0]     csr_write_data = '0;

   // Register copy held by the testbench
   logic [63:0]            sig_low    = '0;
   logic [63:0]            sig_high   = '0;
   logic [WILD_BITS-1:0]   wild_mask  = '0;
   logic [LENGTH_BITS-1:0] sig_length = 5'd1;

   // Scan state of the predictor
   logic [BYTE_BITS-1:0]         window [PATTERN_SLOTS];
   logic [FIELD_OFFSET_BITS-1:0] bytes_seen;
   logic                         scan_done;

   image_word_type image_words[$];
   rsp_word_type   pending_scan_results[$];

   int          idle_pct          = 0;
   int          long_stalls_asked = 0;
   int          long_stalls_done  = 0;
   int          mismatches        = 0;
   int          found_seen        = 0;
   int          miss_seen         = 0;
   int unsigned queued_bytes      = 0;
   int unsigned bytes_accepted    = 0;
   int          quiet_cycles      = 0;

   wildcard_byte_pattern_scan_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {32'($urandom), 32'($urandom)};
   endfunction

   // Length codes of zero read as one; codes past the window read as a full window
   function automatic int unsigned active_length();
      if (sig_length == '0) return 1;
      if (sig_length > PATTERN_SLOTS) return PATTERN_SLOTS;
      return 32'(sig_length);
   endfunction

   function automatic logic [BYTE_BITS-1:0] pattern_at(input int unsigned k);
      if (k < 8) return sig_low[8*k +: 8];
      return sig_high[8*(k-8) +: 8];
   endfunction

   function automatic void clear_scan();
      foreach (window[i]) window[i] = '0;
      bytes_seen = '0;
      scan_done  = 1'b0;
   endfunction

   // Advance the scan by one image byte and queue the result word it gives
   task automatic predict_scan_step(input logic [BYTE_BITS-1:0] data, input logic last);
      int unsigned  n;
      int unsigned  k;
      logic         saturated;
      logic         hit;
      rsp_word_type word;
      n   = active_length();
      hit = 1'b0;
      if (!scan_done) begin
         for (k = PATTERN_SLOTS - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = data;
         saturated = (bytes_seen == '1);
         if (!saturated) bytes_seen = bytes_seen + 1;
         // compare only once the window is full; oldest byte lines up with pattern byte 0
         if (bytes_seen >= n) begin
            hit = 1'b1;
            for (k = 0; k < n; k++) begin
               if (!wild_mask[k] && window[n-1-k] != pattern_at(k)) hit = 1'b0;
            end
            if (hit) begin
               word.found        = 1'b1;
               word.match_offset = saturated ? '1 : bytes_seen - n;
               pending_scan_results = {pending_scan_results, word};
               scan_done = 1'b1;
            end
         end
         if (last && !hit) begin
            word.found        = 1'b0;
            word.match_offset = '0;
            pending_scan_results = {pending_scan_results, word};
         end
      end
      if (last) clear_scan();
   endtask

   function automatic void flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, what);
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_PATTERN_LOW:  sig_low    = value;
         CSR_PATTERN_HIGH: sig_high   = value;
         CSR_WILDCARD:     wild_mask  = value[WILD_BITS-1:0];
         CSR_LENGTH:       sig_length = value[LENGTH_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_word(input logic [BYTE_BITS-1:0] data, input logic last);
      image_word_type w;
      w.data = data;
      w.last = last;
      image_words = {image_words, w};
      queued_bytes++;
   endtask

   // Half the noise is drawn from the pattern itself so partial matches are common
   function automatic logic [BYTE_BITS-1:0] noise_byte();
      if ($urandom_range(0, 1) == 0) return 8'($urandom);
      return pattern_at($urandom_range(0, active_length() - 1));
   endfunction

   // Queue one image: leading noise, optionally the pattern, trailing noise
   task automatic queue_image(input int unsigned lead, input bit plant, input int unsigned tail);
      logic [BYTE_BITS-1:0] bytes[$];
      int unsigned          k;
      repeat (lead) bytes = {bytes, noise_byte()};
      if (plant) begin
         for (k = 0; k < active_length(); k++)
            bytes = {bytes, (wild_mask[k] ? 8'($urandom) : pattern_at(k))};
      end
      repeat (tail) bytes = {bytes, noise_byte()};
      if (bytes.size() == 0) bytes = {bytes, noise_byte()};
      foreach (bytes[i]) queue_word(bytes[i], i == bytes.size() - 1);
   endtask

   // Hold until every word has gone in and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (image_words.size() != 0 || req_valid || pending_scan_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: offer queued words, with random gaps between them
   always @(posedge clock) begin : byte_sender
      logic           next_valid;
      image_word_type w;
      int             gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            predict_scan_step(req_data_byte, req_last_byte);
            bytes_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (image_words.size() != 0) begin
               if ($urandom_range(0, 99) < idle_pct) begin
                  gap_left = $urandom_range(0, 2);
               end else begin
                  w = image_words.pop_front();
                  req_data_byte <= w.data;
                  req_last_byte <= w.last;
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: random short stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin : result_receiver
      int stall_left;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_stalls_done != long_stalls_asked) begin
         long_stalls_done++;
         stall_left = LONG_STALL_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: check each result word against the oldest expectation
   always @(posedge clock) begin : result_monitor
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scan_results.size() == 0) begin
            flag_mismatch($sformatf("result word found=%0b offset=%0d with none expected",
                                    rsp_found, rsp_match_offset));
         end else begin
            want = pending_scan_results.pop_front();
            if (rsp_found !== want.found)
               flag_mismatch($sformatf("found expected %0b got %0b", want.found, rsp_found));
            if (rsp_match_offset !== want.match_offset)
               flag_mismatch($sformatf("match_offset expected %0d got %0d",
                                       want.match_offset, rsp_match_offset));
            if (want.found) found_seen++;
            else miss_seen++;
         end
      end
   end

   // Watchdog: give up when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles with no word moving", WATCHDOG_LIMIT);
         $display("wildcard_byte_pattern_scan_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed images, then phases of random images under varied settings
   initial begin : stimulus
      int unsigned length_plan [PHASE_COUNT];
      int          ph;
      int unsigned pick;
      int unsigned n;
      int unsigned phase_start;
      logic [WILD_BITS-1:0] m;
      length_plan = '{2, 16, 5, 1, 0, 31, 8, 17, 11, 4, 16, 3, 1};
      clear_scan();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: match on the final byte, then an image with no match
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b1);
      queue_word(8'hFF, 1'b1);
      wait_idle();

      // length code zero; bytes after the match are dropped until the final byte
      write_reg(CSR_LENGTH, 64'd0);
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'h00, 1'b1);
      wait_idle();

      // three byte pattern: image shorter than the pattern, then a match at offset one
      write_reg(CSR_LENGTH, 64'd3);
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_5AFF);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h5A, 1'b1);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h5A, 1'b0);
      queue_word(8'h00, 1'b1);
      wait_idle();

      // oversize length code with every byte wild: short image still misses
      write_reg(CSR_PATTERN_HIGH, '1);
      write_reg(CSR_WILDCARD, 64'hFFFF);
      write_reg(CSR_LENGTH, 64'd31);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h7E, 1'b1);
      wait_idle();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 5)
            0: m = '0;
            1: m = 16'($urandom);
            2: m = 16'($urandom) & 16'($urandom) & 16'($urandom);
            3: m = '1;
            default: m = 16'($urandom) | 16'($urandom);
         endcase
         write_reg(CSR_PATTERN_LOW, rand64());
         write_reg(CSR_PATTERN_HIGH, rand64());
         write_reg(CSR_WILDCARD, (rand64() & ~64'hFFFF) | 64'(m));
         write_reg(CSR_LENGTH, (rand64() & ~64'h1F) | 64'(length_plan[ph]));
         // no idling in the closing phases and in every fourth one
         idle_pct <= (ph >= PHASE_COUNT - 2 || ph % 4 == 1) ? 0 : ((ph % 2) ? 25 : 12);
         if (ph == 3) long_stalls_asked <= long_stalls_asked + 1;
         n = active_length();
         phase_start = queued_bytes;
         while (queued_bytes - phase_start < PHASE_BYTES) begin
            if (ph == 3) begin
               // one result per tiny image fills the output buffer during the hold-off
               queue_image(0, 1'b0, $urandom_range(1, 2));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 65)
                  queue_image($urandom_range(0, 10), 1'b1, $urandom_range(0, 4));
               else if (pick < 80)
                  queue_image(0, 1'b0, $urandom_range(1, 20));
               else
                  queue_image(0, 1'b0, $urandom_range(1, (n > 1) ? n - 1 : 1));
            end
         end
         wait_idle();
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("Summary: %0d image bytes over %0d setting phases, length codes 0 to 31",
               bytes_accepted, PHASE_COUNT);
      $display("Summary: %0d matches and %0d unmatched scans checked, %0d mismatches",
               found_seen, miss_seen, mismatches);
      if (mismatches == 0 && pending_scan_results.size() == 0) begin
         $display("wildcard_byte_pattern_scan_core regression: pass");
      end else begin
         $display("wildcard_byte_pattern_scan_core regression: fail");
      end
      $finish;
   end

endmodule
